### hdl/t2i_pkg.sv
// t2i_pkg: types, character codes and digit decoding for the text to int32 parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package t2i_pkg;

  localparam int CHAR_W  = 8;
  localparam int BASE_W  = 6;
  localparam int VALUE_W = 32;
  localparam int OFFS_W  = 16;
  localparam int DIGIT_W = 7;
  localparam int PROD_W  = VALUE_W + BASE_W;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] UPPER_OFFS = CH_UPPER_A - 8'd10;
  localparam logic [CHAR_W-1:0] LOWER_OFFS = CH_LOWER_A - 8'd10;

  localparam logic [DIGIT_W-1:0] NOT_DIGIT = 7'd99;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] RADIX_OCT = 6'd8;
  localparam logic [BASE_W-1:0] RADIX_DEC = 6'd10;
  localparam logic [BASE_W-1:0] RADIX_HEX = 6'd16;

  localparam logic [VALUE_W-1:0] POS_SAT_VALUE = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] NEG_SAT_VALUE = 32'h8000_0000;

  typedef enum logic [2:0] {
    PH_DONE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    logic              start_flag;
    logic [CHAR_W-1:0] character;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [OFFS_W-1:0]         end_offset;
    logic                      overflowed;
    logic                      digits_found;
  } result_t;

  typedef struct packed {
    logic clear;
    logic sign_load;
    logic zero_digit;
    logic digit_take;
    logic pos_inc;
    logic fire;
  } step_ctl_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = '0;
    case (c) inside
      [CH_ZERO:CH_NINE]:        d = c - CH_ZERO;
      [CH_UPPER_A:CH_UPPER_Z]:  d = c - UPPER_OFFS;
      [CH_LOWER_A:CH_LOWER_Z]:  d = c - LOWER_OFFS;
      default:                  d = CHAR_W'(NOT_DIGIT);
    endcase
    return d[DIGIT_W-1:0];
  endfunction

endpackage

### hdl/t2i_if.sv
// t2i channel interfaces: character input, parsed result and base register write
// no dependencies; used by the top level of the parser
`timescale 1ns / 1ps

interface t2i_in_if;
  logic       valid;
  logic       ready;
  logic       start_flag;
  logic [7:0] character;
  modport source (output valid, output start_flag, output character, input ready);
  modport sink   (input valid, input start_flag, input character, output ready);
endinterface

interface t2i_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [15:0]        end_offset;
  logic               overflowed;
  logic               digits_found;
  modport source (output valid, output value, output end_offset, output overflowed,
                  output digits_found, input ready);
  modport sink   (input valid, input value, input end_offset, input overflowed,
                  input digits_found, output ready);
endinterface

interface t2i_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] number_base;
  modport source (output valid, output number_base, input ready);
  modport sink   (input valid, input number_base, output ready);
endinterface

### hdl/t2i_in_reg.sv
// t2i_in_reg: input register holding one character request for the step logic
// depends on t2i_pkg
`timescale 1ns / 1ps

module t2i_in_reg import t2i_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### hdl/t2i_core.sv
// t2i_core: parse state and combinational step logic (sign, prefix, digit accumulate)
// depends on t2i_pkg
`timescale 1ns / 1ps

module t2i_core import t2i_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  item_t             item,
  input  logic [BASE_W-1:0] number_base,
  output logic              fire,
  output result_t           result
);

  phase_t                   phase_r, phase_nxt, ph;
  logic [VALUE_W-1:0]       acc_r, acc_nxt, acc_c;
  logic                     neg_r, neg_nxt, neg_c;
  logic                     any_r, any_nxt, any_c;
  logic                     ovf_r, ovf_nxt, ovf_c;
  logic [BASE_W-1:0]        radix_r, radix_eff;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_c;
  logic [POSITION_BITS+OFFS_W-1:0] pos_ext;

  step_ctl_t          ctl;
  logic               stop;
  logic [DIGIT_W-1:0] dval;
  logic               is_ws, is_sign, is_zero, is_x, base_auto, base_hex;
  logic [PROD_W-1:0]  prod, limit;
  logic               over;
  logic               found;

  assign dval      = digit_of(item.character);
  assign is_ws     = (item.character == CH_SPACE) ||
                     (item.character >= CH_TAB && item.character <= CH_CR);
  assign is_sign   = (item.character == CH_PLUS) || (item.character == CH_MINUS);
  assign is_zero   = (item.character == CH_ZERO);
  assign is_x      = (item.character == CH_LOWER_X) || (item.character == CH_UPPER_X);
  assign base_auto = (number_base == BASE_AUTO);
  assign base_hex  = (number_base == RADIX_HEX);

  // next phase and step controls
  always_comb begin
    ph        = phase_r;
    phase_nxt = phase_r;
    radix_eff = radix_r;
    ctl       = '0;
    stop      = 1'b0;
    if (step_en && (item.start_flag || phase_r != PH_DONE)) begin
      if (item.start_flag) begin
        ph        = PH_LEAD;
        radix_eff = '0;
        ctl.clear = 1'b1;
      end
      if (ph == PH_LEAD) begin
        if (is_ws) begin
          ctl.pos_inc = 1'b1;
          stop        = 1'b1;
        end else begin
          ph = PH_SIGNED;
          if (is_sign) begin
            ctl.sign_load = 1'b1;
            ctl.pos_inc   = 1'b1;
            stop          = 1'b1;
          end
        end
      end
      if (!stop) begin
        if (ph == PH_SIGNED) begin
          if (is_zero && (base_auto || base_hex)) begin
            radix_eff   = base_auto ? RADIX_OCT : RADIX_HEX;
            ph          = PH_ZERO;
            ctl.pos_inc = 1'b1;
            stop        = 1'b1;
          end else begin
            radix_eff = base_auto ? RADIX_DEC : number_base;
            ph        = PH_DIGITS;
          end
        end else if (ph == PH_ZERO) begin
          ph = PH_DIGITS;
          if (is_x) begin
            radix_eff   = RADIX_HEX;
            ctl.pos_inc = 1'b1;
            stop        = 1'b1;
          end else begin
            ctl.zero_digit = 1'b1;
          end
        end
      end
      if (!stop) begin
        if (dval >= DIGIT_W'(radix_eff)) begin
          ctl.fire = 1'b1;
          ph       = PH_DONE;
        end else begin
          ctl.digit_take = 1'b1;
          ctl.pos_inc    = 1'b1;
        end
      end
      phase_nxt = ph;
    end
  end

  // datapath and result
  always_comb begin
    acc_c   = ctl.clear ? '0 : acc_r;
    neg_c   = ctl.clear ? 1'b0 : neg_r;
    any_c   = ctl.clear ? 1'b0 : any_r;
    ovf_c   = ctl.clear ? 1'b0 : ovf_r;
    pos_c   = ctl.clear ? '0 : pos_r;
    prod    = PROD_W'(acc_c) * PROD_W'(radix_eff) + PROD_W'(dval);
    limit   = PROD_W'(neg_c ? NEG_SAT_VALUE : POS_SAT_VALUE);
    over    = ovf_c || (prod > limit);
    neg_nxt = ctl.sign_load ? (item.character == CH_MINUS) : neg_c;
    acc_nxt = (ctl.digit_take && !over) ? prod[VALUE_W-1:0] : acc_c;
    any_nxt = any_c || ctl.zero_digit || (ctl.digit_take && !over);
    ovf_nxt = ovf_c || (ctl.digit_take && over);
    pos_nxt = pos_c + POSITION_BITS'(ctl.pos_inc);
    pos_ext = (POSITION_BITS + OFFS_W)'(pos_c);

    // the zero before a non-prefix character counts as a digit
    found = any_c || ctl.zero_digit || ovf_c;

    fire = ctl.fire;
    if (ovf_c) begin
      result.value = neg_c ? NEG_SAT_VALUE : POS_SAT_VALUE;
    end else if (neg_c) begin
      result.value = VALUE_W'(0) - acc_c;
    end else begin
      result.value = acc_c;
    end
    result.end_offset   = found ? pos_ext[OFFS_W-1:0] : '0;
    result.overflowed   = ovf_c;
    result.digits_found = found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      any_r   <= 1'b0;
      ovf_r   <= 1'b0;
      radix_r <= '0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      any_r   <= any_nxt;
      ovf_r   <= ovf_nxt;
      radix_r <= radix_eff;
      pos_r   <= pos_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_fire_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> step_en)
    else $error("result raised without a character in the step stage");

  a_done_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> phase_r == PH_DONE)
    else $error("parser did not return to done after a result");

  a_radix_in_digits: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DIGITS |-> radix_r != '0)
    else $error("digit phase entered without a radix");

  a_ovf_only_late: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (phase_r == PH_DIGITS || phase_r == PH_DONE))
    else $error("overflow flagged before any digit phase");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r && step_en && !item.start_flag) |=> ovf_r)
    else $error("overflow flag lost within a string");
`endif

endmodule

### hdl/t2i_out_reg.sv
// t2i_out_reg: result register decoupling the step logic from the result consumer
// depends on t2i_pkg
`timescale 1ns / 1ps

module t2i_out_reg import t2i_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

### hdl/text_to_int32_parser.sv
// text_to_int32_parser: streaming strtol style parser, top level
// depends on t2i_pkg, t2i_if, t2i_in_reg, t2i_core and t2i_out_reg
`timescale 1ns / 1ps

// Takes one ASCII character per request, marked by start_flag at the first
// character of each string, and returns one result on the character that ends
// the number. Throughput is one character per clock while the output can
// advance: the step logic does one 32 by 6 bit multiply, an add and a limit
// compare per character, between the input register and the result register.
// While a result waits, the step logic stalls and only an empty input register
// can still take a character. number_base is read when the first character
// after the optional sign is processed; write it only while the block is idle.

module text_to_int32_parser import t2i_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  t2i_in_if.sink     in_ch,
  t2i_out_if.source  out_ch,
  t2i_cfg_if.sink    cfg_ch
);

  logic [BASE_W-1:0] base_r;
  item_t             in_item;
  item_t             item;
  logic              item_valid;
  logic              advance;
  logic              fire;
  result_t           step_res;
  result_t           out_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_AUTO;
    end else if (cfg_ch.valid) begin
      base_r <= cfg_ch.number_base;
    end
  end

  assign in_item.start_flag = in_ch.start_flag;
  assign in_item.character  = in_ch.character;

  t2i_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  t2i_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (item_valid && advance),
    .item        (item),
    .number_base (base_r),
    .fire        (fire),
    .result      (step_res)
  );

  t2i_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .load_data (step_res),
    .advance   (advance),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_res)
  );

  assign out_ch.value        = out_res.value;
  assign out_ch.end_offset   = out_res.end_offset;
  assign out_ch.overflowed   = out_res.overflowed;
  assign out_ch.digits_found = out_res.digits_found;

endmodule
